// ===== rtl/luhn_pkg.sv =====
// Shared constants and control types for the Luhn card number checker.
package luhn_pkg;

	// Width of the card number field and the number of its low bits that count.
	localparam int CARD_W      = 63;
	localparam int NUMBER_BITS = 63;

	// Decimal digits held by the converter; twenty cover any 64-bit value.
	localparam int DIGITS = 20;
	localparam int BCD_W  = DIGITS * 4;

	// The converter takes four binary bits per cycle.
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS    = (NUMBER_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_BITS      = CONV_STEPS * BITS_PER_STEP;

	localparam int STEP_W  = $clog2((CONV_STEPS > DIGITS) ? CONV_STEPS : DIGITS);
	localparam int COUNT_W = 5;

	localparam logic [63:0] NUM_MASK = {64{1'b1}} >> (64 - NUMBER_BITS);

	localparam logic [1:0] VERDICT_INVALID    = 2'd0;
	localparam logic [1:0] VERDICT_AMEX       = 2'd1;
	localparam logic [1:0] VERDICT_MASTERCARD = 2'd2;
	localparam logic [1:0] VERDICT_VISA       = 2'd3;

	typedef struct packed {
		logic load;
		logic conv;
		logic scan;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic conv_last;
		logic scan_last;
	} status_t;

endpackage

// ===== rtl/luhn_ifs.sv =====
// Valid/ready channel interfaces for card numbers and check results.
interface luhn_in_if;
	logic                         valid;
	logic                         ready;
	logic [luhn_pkg::CARD_W-1:0]  card_number;

	modport source (output valid, output card_number, input ready);
	modport sink (input valid, input card_number, output ready);
endinterface

interface luhn_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    verdict;
	logic                          luhn_ok;
	logic [luhn_pkg::COUNT_W-1:0]  digit_count;

	modport source (output valid, output verdict, output luhn_ok, output digit_count,
		input ready);
	modport sink (input valid, input verdict, input luhn_ok, input digit_count,
		output ready);
endinterface

// ===== rtl/luhn_card_number_check_core.sv =====
// Luhn card number checker: accepts a binary card number and returns its digit
// count, the Luhn mod-10 verdict and the card class (AMEX, Mastercard, Visa).
// A number passes through these steps before a new one can be taken: a load,
// binary to decimal conversion at four bits per cycle, a scan in which the
// digit scanner walks one decimal digit per cycle from the low end, and a
// classification into the result register once the previous result has gone.
// The result register holds its transaction until the sink takes it, while the
// block already accepts and works on the next number.
module luhn_card_number_check_core (
	input  logic        clk,
	input  logic        arst_n,
	luhn_in_if.sink     number,
	luhn_out_if.source  result
);

	luhn_pkg::cmd_t    cmd;
	luhn_pkg::status_t status;

	luhn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number.valid),
		.in_ready  (number.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	luhn_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.card_number (number.card_number),
		.verdict     (result.verdict),
		.luhn_ok     (result.luhn_ok),
		.digit_count (result.digit_count)
	);

endmodule

// ===== rtl/luhn_dp.sv =====
// Datapath: binary to decimal conversion, Luhn digit scan and classification.
module luhn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  luhn_pkg::cmd_t               cmd,
	output luhn_pkg::status_t            status,
	input  logic [luhn_pkg::CARD_W-1:0]  card_number,
	output logic [1:0]                   verdict,
	output logic                         luhn_ok,
	output logic [luhn_pkg::COUNT_W-1:0] digit_count
);

	logic [luhn_pkg::PAD_BITS-1:0] bin_q;
	logic [luhn_pkg::BCD_W-1:0]    bcd_q;
	logic [luhn_pkg::STEP_W-1:0]   step_q;
	logic [3:0]                    sum_q;
	logic [3:0]                    prev_q;
	logic [3:0]                    lead_hi_q;
	logic [3:0]                    lead_lo_q;
	logic [luhn_pkg::COUNT_W-1:0]  count_q;

	logic [luhn_pkg::PAD_BITS-1:0] bin_next;
	logic [luhn_pkg::BCD_W-1:0]    bcd_next;
	logic [63:0]                   value64;
	logic [3:0]                    digit;
	logic [4:0]                    dbl;
	logic [3:0]                    term;
	logic [4:0]                    sum_raw;
	logic [3:0]                    sum_next;
	logic [6:0]                    pair;
	logic [1:0]                    verdict_next;

	assign status.conv_last = (step_q == luhn_pkg::STEP_W'(luhn_pkg::CONV_STEPS - 1));
	assign status.scan_last = (step_q == luhn_pkg::STEP_W'(luhn_pkg::DIGITS - 1));

	assign value64 = 64'(card_number) & luhn_pkg::NUM_MASK;

	// Four shift-and-add-3 steps per cycle; each digit is corrected before every shift.
	always_comb begin
		bin_next = bin_q;
		bcd_next = bcd_q;
		for (int k = 0; k < luhn_pkg::BITS_PER_STEP; k++) begin
			for (int j = 0; j < luhn_pkg::DIGITS; j++) begin
				if (bcd_next[j*4 +: 4] >= 4'd5) begin
					bcd_next[j*4 +: 4] = bcd_next[j*4 +: 4] + 4'd3;
				end
			end
			bcd_next = {bcd_next[luhn_pkg::BCD_W-2:0], bin_next[luhn_pkg::PAD_BITS-1]};
			bin_next = {bin_next[luhn_pkg::PAD_BITS-2:0], 1'b0};
		end
	end

	// Digits leave the low end one per cycle; odd positions are doubled.
	always_comb begin
		digit = bcd_q[3:0];
		dbl   = {digit, 1'b0};
		if (step_q[0]) begin
			term = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
		end else begin
			term = digit;
		end
		sum_raw  = 5'(sum_q) + 5'(term);
		sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
	end

	always_comb begin
		pair         = 7'(lead_hi_q) * 7'd10 + 7'(lead_lo_q);
		verdict_next = luhn_pkg::VERDICT_INVALID;
		if (sum_q == 4'd0 && count_q != '0) begin
			case (count_q)
				luhn_pkg::COUNT_W'(15): begin
					if (pair == 7'd34 || pair == 7'd37) begin
						verdict_next = luhn_pkg::VERDICT_AMEX;
					end
				end
				luhn_pkg::COUNT_W'(16): begin
					if (pair >= 7'd51 && pair <= 7'd55) begin
						verdict_next = luhn_pkg::VERDICT_MASTERCARD;
					end else if (lead_hi_q == 4'd4) begin
						verdict_next = luhn_pkg::VERDICT_VISA;
					end
				end
				luhn_pkg::COUNT_W'(13): begin
					if (lead_hi_q == 4'd4) begin
						verdict_next = luhn_pkg::VERDICT_VISA;
					end
				end
				default: begin
					verdict_next = luhn_pkg::VERDICT_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.conv) begin
			step_q <= status.conv_last ? '0 : step_q + 1'b1;
		end else if (cmd.scan) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q     <= luhn_pkg::PAD_BITS'(value64);
			bcd_q     <= '0;
			sum_q     <= '0;
			prev_q    <= '0;
			lead_hi_q <= '0;
			lead_lo_q <= '0;
			count_q   <= '0;
		end else if (cmd.conv) begin
			bin_q <= bin_next;
			bcd_q <= bcd_next;
		end else if (cmd.scan) begin
			bcd_q  <= {4'd0, bcd_q[luhn_pkg::BCD_W-1:4]};
			sum_q  <= sum_next;
			prev_q <= digit;
			// The most recent nonzero digit is the leading one; the digit below it
			// is the second of the leading pair.
			if (digit != 4'd0) begin
				count_q   <= luhn_pkg::COUNT_W'(step_q) + 1'b1;
				lead_hi_q <= digit;
				lead_lo_q <= prev_q;
			end
		end
		if (cmd.load_result) begin
			verdict     <= verdict_next;
			luhn_ok     <= (sum_q == 4'd0);
			digit_count <= count_q;
		end
	end

endmodule

// ===== rtl/luhn_ctrl.sv =====
// Controller: sequences conversion and scan and owns the handshakes.
module luhn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  luhn_pkg::status_t  status,
	output luhn_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign cmd.load        = in_ready && in_valid;
	assign cmd.conv        = (state_q == S_CONV);
	assign cmd.scan        = (state_q == S_SCAN);
	// The result register is refilled once the previous result has gone.
	assign cmd.load_result = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (status.conv_last) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (status.scan_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.load_result) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
